FILE: src/sppe_pkg.sv
// ============================================================================
// sppe_pkg
// Shared types, request codes and constants of the stack push/pop engine.
// ============================================================================
package sppe_pkg;

    localparam int MEM_BYTES_DEF = 4096;
    localparam int NUM_REGS      = 16;
    localparam int RED_BITS      = 4;

    localparam logic [3:0]  SP_INDEX    = 4'd13;
    localparam logic [31:0] FRAME_BYTES = 32'd44;
    localparam logic [15:0] FRAME_MASK  = 16'hD00F;
    localparam logic [15:0] WORD_MASK   = 16'h0001;
    localparam logic [4:0]  LAST_SLOT   = 5'd20;

    localparam logic [3:0] REQ_PUSH   = 4'd0;
    localparam logic [3:0] REQ_POP    = 4'd1;
    localparam logic [3:0] REQ_ENTRY  = 4'd2;
    localparam logic [3:0] REQ_RETURN = 4'd3;
    localparam logic [3:0] REQ_WREG   = 4'd4;
    localparam logic [3:0] REQ_RREG   = 4'd5;
    localparam logic [3:0] REQ_WFLAGS = 4'd6;
    localparam logic [3:0] REQ_RMEM   = 4'd7;
    localparam logic [3:0] REQ_WMEM   = 4'd8;

    typedef struct packed {
        logic        we;
        logic [3:0]  waddr;
        logic [31:0] wdata;
        logic [3:0]  raddr;
    } t_rf_req;

endpackage

FILE: src/sppe_regfile.sv
// ============================================================================
// sppe_regfile
// Sixteen 32-bit registers in a synchronous memory with one write port and a
// registered read port. Entries not yet written read as zero.
// ============================================================================
module sppe_regfile
    import sppe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rf_req     i_req,
    output logic [31:0] o_rdata
);

    logic [31:0]         r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [31:0]         r_rdata;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_req.raddr];
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : 32'd0;

endmodule

FILE: src/sppe_stack_mem.sv
// ============================================================================
// sppe_stack_mem
// Byte-wide stack memory, single port, read data registered.
// ============================================================================
module sppe_stack_mem
    import sppe_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic [$clog2(MEM_BYTES)-1:0] i_addr,
    input  logic                         i_we,
    input  logic [7:0]                   i_wdata,
    output logic [7:0]                   o_rdata
);

    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/sppe_addr_mod.sv
// ============================================================================
// sppe_addr_mod
// Reduces a 32-bit byte address modulo the memory size, a few bits a cycle,
// by shift, compare and subtract.
// ============================================================================
module sppe_addr_mod
    import sppe_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [31:0]                  i_value,
    output logic                         o_done,
    output logic [$clog2(MEM_BYTES)-1:0] o_rem
);

    localparam int AW    = $clog2(MEM_BYTES);
    localparam int STEPS = 32 / RED_BITS;
    localparam int CW    = $clog2(STEPS);
    localparam logic [AW:0]   MOD      = (AW+1)'(MEM_BYTES);
    localparam logic [CW-1:0] CNT_LAST = CW'(STEPS - 1);

    logic [31:0]   r_val;
    logic [AW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [AW-1:0] n_rem;

    always_comb begin
        logic [AW:0] w;
        n_rem = r_rem;
        for (int b = 0; b < RED_BITS; b++) begin
            w = {n_rem, r_val[31-b]};
            if (w >= MOD) begin
                w = w - MOD;
            end
            n_rem = w[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= r_val << RED_BITS;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: src/stack_push_pop_engine_top.sv
// ============================================================================
// stack_push_pop_engine_top
// Register file, flags and byte stack memory with list push/pop, exception
// frame stacking and single register, flag and memory word accesses.
//
//   Channel   Handshake           Signals
//   request   start, busy         i_req_type, i_reg_mask, i_reg_index,
//                                 i_data_value, i_mem_address, i_flags_in
//   result    o_valid (strobe)    o_read_value, o_stack_pointer, o_flags_out
//
// A request is taken when start is high and busy is low; its result is a
// one-cycle strobe in the first cycle with busy low again. Register writes,
// flag writes and unknown requests go straight to the closing state; a
// register read passes through a read state first. Memory requests first
// reduce the start address, then visit each slot once (the listed registers,
// the frame's registers and flags, or the single word); an enabled word is
// stored byte by byte, or loaded byte by byte and taken in a load-end state,
// through the byte-wide memory port. Every request ends in a closing state.
// Reset is synchronous and clears the registers and flags; the stack memory
// holds no reset value. The result cannot be stalled.
// ============================================================================
module stack_push_pop_engine_top
    import sppe_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_req_type,
    input  logic [15:0] i_reg_mask,
    input  logic [3:0]  i_reg_index,
    input  logic [31:0] i_data_value,
    input  logic [11:0] i_mem_address,
    input  logic [3:0]  i_flags_in,
    output logic        o_valid,
    output logic [31:0] o_read_value,
    output logic [31:0] o_stack_pointer,
    output logic [3:0]  o_flags_out
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MEM_BYTES - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_REDUCE = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_STORE  = 4'd3;
    localparam logic [3:0] S_LOAD   = 4'd4;
    localparam logic [3:0] S_LDEND  = 4'd5;
    localparam logic [3:0] S_RDREG  = 4'd6;
    localparam logic [3:0] S_FINISH = 4'd7;

    logic [3:0]    r_state;
    logic [3:0]    r_op;
    logic [15:0]   r_mask;
    logic          r_frame;
    logic [4:0]    r_n;
    logic [3:0]    r_idx;
    logic [31:0]   r_data;
    logic [31:0]   r_addr32;
    logic [AW-1:0] r_addr;
    logic [4:0]    r_slot;
    logic [1:0]    r_k;
    logic [23:0]   r_word;
    logic [31:0]   r_rdv;
    logic [31:0]   r_sp;
    logic [3:0]    r_flags;

    logic          accept;
    logic [4:0]    n_cnt;
    logic [31:0]   base;
    logic          red_start;
    logic          red_done;
    logic [AW-1:0] red_rem;
    logic [AW-1:0] n_addr;
    logic          slot_en;
    logic          slots_done;
    logic          is_store;
    logic [31:0]   st_word;
    logic [31:0]   ld_word;
    logic [7:0]    mem_rdata;
    logic [31:0]   rf_rdata;
    logic [31:0]   n_sp;
    t_rf_req       rf_req;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_cnt = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            n_cnt = n_cnt + 5'(i_reg_mask[i]);
        end
    end

    always_comb begin
        case (i_req_type)
            REQ_PUSH:  base = r_sp - {25'd0, n_cnt, 2'b00};
            REQ_ENTRY: base = r_sp - FRAME_BYTES;
            REQ_RMEM:  base = {20'd0, i_mem_address};
            REQ_WMEM:  base = {20'd0, i_mem_address};
            default:   base = r_sp;
        endcase
    end

    assign red_start = accept && (i_req_type == REQ_PUSH || i_req_type == REQ_POP ||
                                  i_req_type == REQ_ENTRY || i_req_type == REQ_RETURN ||
                                  i_req_type == REQ_RMEM || i_req_type == REQ_WMEM);

    assign n_addr = (r_addr32 == 32'hFFFF_FFFF || r_addr == ADDR_LAST) ? '0 : r_addr + 1'b1;

    assign slot_en = r_slot[4] ? (r_frame && r_slot != LAST_SLOT) : r_mask[r_slot[3:0]];
    assign slots_done = (r_slot == LAST_SLOT) || (r_slot[4] && !r_frame) ||
                        ((r_op == REQ_RMEM || r_op == REQ_WMEM) && r_slot != 5'd0);
    assign is_store = (r_op == REQ_PUSH) || (r_op == REQ_ENTRY) || (r_op == REQ_WMEM);

    always_comb begin
        if (r_op == REQ_WMEM) begin
            st_word = r_data;
        end else if (r_slot[4]) begin
            st_word = {31'd0, r_flags[r_slot[1:0]]};
        end else if (r_slot[3:0] == SP_INDEX) begin
            st_word = r_sp;
        end else begin
            st_word = rf_rdata;
        end
    end

    assign ld_word = {mem_rdata, r_word};

    always_comb begin
        case (r_op)
            REQ_PUSH:   n_sp = r_sp - {25'd0, r_n, 2'b00};
            REQ_POP:    n_sp = r_sp + {25'd0, r_n, 2'b00};
            REQ_ENTRY:  n_sp = r_sp - FRAME_BYTES;
            REQ_RETURN: n_sp = r_sp + FRAME_BYTES;
            default:    n_sp = r_sp;
        endcase
    end

    always_comb begin
        rf_req.we    = (accept && i_req_type == REQ_WREG && i_reg_index != SP_INDEX) ||
                       (r_state == S_LDEND && !r_slot[4] && r_slot[3:0] != SP_INDEX &&
                        r_op != REQ_RMEM);
        rf_req.waddr = (r_state == S_IDLE) ? i_reg_index : r_slot[3:0];
        rf_req.wdata = (r_state == S_IDLE) ? i_data_value : ld_word;
        rf_req.raddr = (r_state == S_IDLE) ? i_reg_index : r_slot[3:0];
    end

    sppe_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rf_req),
        .o_rdata (rf_rdata)
    );

    sppe_stack_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_addr  (r_addr),
        .i_we    (r_state == S_STORE),
        .i_wdata (st_word[8*r_k +: 8]),
        .o_rdata (mem_rdata)
    );

    sppe_addr_mod #(
        .MEM_BYTES (MEM_BYTES)
    ) u_addr_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_value (base),
        .o_done  (red_done),
        .o_rem   (red_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_k     <= '0;
            r_sp    <= '0;
            r_flags <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_req_type)
                            REQ_PUSH, REQ_POP, REQ_ENTRY, REQ_RETURN, REQ_RMEM, REQ_WMEM: begin
                                r_state <= S_REDUCE;
                            end
                            REQ_WREG: begin
                                if (i_reg_index == SP_INDEX) begin
                                    r_sp <= i_data_value;
                                end
                                r_state <= S_FINISH;
                            end
                            REQ_RREG: begin
                                r_state <= S_RDREG;
                            end
                            REQ_WFLAGS: begin
                                r_flags <= i_flags_in;
                                r_state <= S_FINISH;
                            end
                            default: begin
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_REDUCE: begin
                    if (red_done) begin
                        r_slot  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_k <= '0;
                    if (slots_done) begin
                        r_state <= S_FINISH;
                    end else if (slot_en) begin
                        r_state <= is_store ? S_STORE : S_LOAD;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                S_STORE: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_LOAD: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_state <= S_LDEND;
                    end
                end
                S_LDEND: begin
                    if (r_op != REQ_RMEM) begin
                        if (r_slot[4]) begin
                            r_flags[r_slot[1:0]] <= ld_word[0];
                        end else if (r_slot[3:0] == SP_INDEX) begin
                            r_sp <= ld_word;
                        end
                    end
                    r_slot  <= r_slot + 1'b1;
                    r_state <= S_SCAN;
                end
                S_RDREG: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_sp    <= n_sp;
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_req_type;
            r_idx    <= i_reg_index;
            r_data   <= i_data_value;
            r_n      <= n_cnt;
            r_rdv    <= '0;
            r_addr32 <= base;
            case (i_req_type)
                REQ_ENTRY, REQ_RETURN: begin
                    r_mask  <= FRAME_MASK;
                    r_frame <= 1'b1;
                end
                REQ_RMEM, REQ_WMEM: begin
                    r_mask  <= WORD_MASK;
                    r_frame <= 1'b0;
                end
                default: begin
                    r_mask  <= i_reg_mask;
                    r_frame <= 1'b0;
                end
            endcase
        end
        if (r_state == S_REDUCE && red_done) begin
            r_addr <= red_rem;
        end
        if (r_state == S_STORE || r_state == S_LOAD) begin
            r_addr   <= n_addr;
            r_addr32 <= r_addr32 + 32'd1;
        end
        if (r_state == S_LOAD && r_k != 2'd0) begin
            r_word <= {mem_rdata, r_word[23:8]};
        end
        if (r_state == S_LDEND && r_op == REQ_RMEM) begin
            r_rdv <= ld_word;
        end
        if (r_state == S_RDREG) begin
            r_rdv <= (r_idx == SP_INDEX) ? r_sp : rf_rdata;
        end
        if (r_state == S_FINISH) begin
            o_read_value    <= r_rdv;
            o_stack_pointer <= n_sp;
            o_flags_out     <= r_flags;
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("Accepted transaction did not make the engine busy.");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("Result strobe raised while the engine is still busy.");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("Result strobe held for more than one cycle.");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE || r_state == S_LOAD) |-> (r_slot < LAST_SLOT))
        else $error("Memory access issued for a slot beyond the frame.");

endmodule
